// ===== src/cmr_pkg.sv =====
// ----------------------------------------------------------------------------
// cmr_pkg
// Shared types, constants and helpers of the Catmull-Rom spline evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package cmr_pkg;

    // fixed point layout
    localparam int COORD_FRAC_DEF = 16;
    localparam int T_FRAC         = 16;
    localparam int R_FRAC         = 24;
    localparam int KNOT_BITS      = 20;
    localparam int TT_W           = 38;
    localparam int QUO_W          = TT_W + R_FRAC;
    localparam logic [16:0] T_ONE = 17'h10000;
    localparam logic signed [63:0] SAT_MAX = 64'sh3FFF_FFFF_FFFF_FFFF;

    // item queue between front and back
    localparam int QDEPTH = 2;
    localparam int QP_W   = $clog2(QDEPTH);
    localparam int QC_W   = $clog2(QDEPTH + 1);

    // item kinds
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    // knot exponent codes
    localparam logic [1:0] ALPHA_UNIFORM = 2'd0;
    localparam logic [1:0] ALPHA_CENTRIP = 2'd1;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [16:0]        t;
    } t_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEG,
        S_SQ,
        S_RT1,
        S_RT2,
        S_NORM,
        S_TT,
        S_DIV,
        S_LERP,
        S_OUT
    } t_state;

    // clamp a sum to the intermediate range
    function automatic logic signed [63:0] clamp_sat(input logic signed [64:0] v);
        logic signed [64:0] hi;
        logic signed [64:0] lo;
        hi = 65'(SAT_MAX);
        lo = -hi;
        if (v > hi) begin
            return SAT_MAX;
        end else if (v < lo) begin
            return -SAT_MAX;
        end
        return v[63:0];
    endfunction

    // clamp to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // sign extension of a coordinate
    function automatic logic signed [63:0] sx64(input logic signed [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

endpackage

`default_nettype wire

// ===== src/cmr_div.sv =====
// ----------------------------------------------------------------------------
// cmr_div
// Bit-serial restoring divider for the knot ratios, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cmr_div
    import cmr_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_go,
    input  wire logic [TT_W-1:0]  i_num,
    input  wire logic [TT_W-1:0]  i_den,
    output logic                  o_done,
    output logic [QUO_W-1:0]      o_quo
);

    localparam int CNT_W = $clog2(QUO_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [TT_W-1:0]  r_rem;
    logic [TT_W-1:0]  r_den;
    logic [QUO_W-1:0] r_q;
    logic [TT_W:0]    rem_sh;
    logic             q_bit;
    logic [TT_W:0]    rem_sub;

    // one restoring step
    always_comb begin
        rem_sh  = {r_rem, r_q[QUO_W-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        q_bit   = (rem_sh >= {1'b0, r_den});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_q   <= {i_num, {R_FRAC{1'b0}}};
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[QUO_W-2:0], q_bit};
            r_rem <= q_bit ? rem_sub[TT_W-1:0] : rem_sh[TT_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

`default_nettype wire

// ===== src/cmr_isqrt.sv =====
// ----------------------------------------------------------------------------
// cmr_isqrt
// Iterative floor square root of a 64-bit value, one result bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cmr_isqrt
    import cmr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_go,
    input  wire logic [63:0] i_val,
    output logic             o_done,
    output logic [31:0]      o_root
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_v;
    logic [63:0] r_r;
    logic [63:0] r_b;
    logic [63:0] trial;
    logic        take;

    always_comb begin
        trial = r_r + r_b;
        take  = (r_v >= trial);
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_v <= i_val;
            r_r <= '0;
            r_b <= 64'h4000_0000_0000_0000;
        end else if (r_busy) begin
            if (take) begin
                r_v <= r_v - trial;
                r_r <= (r_r >> 1) + r_b;
            end else begin
                r_r <= r_r >> 1;
            end
            r_b <= r_b >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[31:0];

endmodule

`default_nettype wire

// ===== src/cmr_back.sv =====
// ----------------------------------------------------------------------------
// cmr_back
// Sequencer that runs pushes and evaluations on a shared multiplier,
// divider and square root unit, with the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cmr_back
    import cmr_pkg::*;
#(
    parameter int COORD_FRAC_BITS = COORD_FRAC_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [1:0]  i_alpha_mode,
    input  wire logic        i_q_valid,
    input  wire t_item       i_q_item,
    output logic             o_q_pop,
    output logic             o_m_valid,
    input  wire logic        i_m_ready,
    output logic [31:0]      o_m_x,
    output logic [31:0]      o_m_y,
    output logic [31:0]      o_m_z,
    output logic             o_m_degen
);

    t_state r_state, n_state;

    logic signed [31:0] r_wx [4];
    logic signed [31:0] r_wy [4];
    logic signed [31:0] r_wz [4];
    logic [2:0]  r_pts;
    logic [16:0] r_u;
    logic        r_big;
    logic [1:0]  r_seg;
    logic [1:0]  r_comp;
    logic [2:0]  r_step;
    logic [2:0]  r_idx;
    logic [2:0]  r_cnt;
    logic [63:0] r_sq;
    logic [31:0] r_k0, r_k1, r_k2;
    logic [TT_W-1:0] r_tt;
    logic signed [63:0] r_r0, r_r1, r_r2, r_r3, r_r4;
    logic signed [63:0] r_a1, r_a2, r_a3, r_b1, r_b2;
    logic signed [63:0] r_d;
    logic [111:0] r_acc;
    logic [63:0]  r_prod;
    logic signed [31:0] r_rx, r_ry, r_rz;
    logic        r_degen;
    logic        r_rt_go, r_dv_go;
    logic        r_ovalid;
    logic [31:0] r_ox, r_oy, r_oz;
    logic        r_odeg;

    logic        rt_done, dv_done;
    logic [31:0] rt_root;
    logic [QUO_W-1:0] dv_quo;

    logic [1:0]  sel_c;
    logic signed [31:0] c_p0, c_p1, c_p2, c_p3, p_lo, p_hi;
    logic signed [32:0] d_cur;
    logic [32:0] m_full;
    logic [31:0] m_cur;
    logic        big_all;
    logic        seg_eq;
    logic        hi_bits;
    logic        centrip;
    logic [31:0] mul_a, mul_b;
    logic [TT_W-1:0] t1, t2, t3, dv_num, dv_den;
    logic signed [63:0] l_p, l_q, l_r;
    logic [63:0] dm, rm;
    logic [1:0]  j_iss, j_acc;
    logic [111:0] pp_sh;
    logic [63:0]  v_mag;
    logic signed [63:0] v_term;
    logic signed [63:0] l_res;
    logic        out_free;

    assign centrip  = (i_alpha_mode == ALPHA_CENTRIP);
    assign out_free = !r_ovalid || i_m_ready;

    // component and segment selection
    always_comb begin
        sel_c = (r_state == S_LERP) ? r_comp : r_cnt[1:0];
        case (sel_c)
            2'd0: begin
                c_p0 = r_wx[0]; c_p1 = r_wx[1]; c_p2 = r_wx[2]; c_p3 = r_wx[3];
            end
            2'd1: begin
                c_p0 = r_wy[0]; c_p1 = r_wy[1]; c_p2 = r_wy[2]; c_p3 = r_wy[3];
            end
            default: begin
                c_p0 = r_wz[0]; c_p1 = r_wz[1]; c_p2 = r_wz[2]; c_p3 = r_wz[3];
            end
        endcase
        case (r_seg)
            2'd0: begin
                p_lo = c_p0; p_hi = c_p1;
                seg_eq = (r_wx[0] == r_wx[1]) && (r_wy[0] == r_wy[1]) && (r_wz[0] == r_wz[1]);
            end
            2'd1: begin
                p_lo = c_p1; p_hi = c_p2;
                seg_eq = (r_wx[1] == r_wx[2]) && (r_wy[1] == r_wy[2]) && (r_wz[1] == r_wz[2]);
            end
            default: begin
                p_lo = c_p2; p_hi = c_p3;
                seg_eq = (r_wx[2] == r_wx[3]) && (r_wy[2] == r_wy[3]) && (r_wz[2] == r_wz[3]);
            end
        endcase
        d_cur  = {p_hi[31], p_hi} - {p_lo[31], p_lo};
        m_full = d_cur[32] ? 33'(-d_cur) : 33'(d_cur);
        m_cur  = r_big ? m_full[32:1] : m_full[31:0];
    end

    // any difference of the window at or above 2^31 in magnitude
    always_comb begin
        logic signed [32:0] dd;
        logic [32:0] dmag;
        big_all = 1'b0;
        for (int i = 0; i < 3; i++) begin
            dd = {r_wx[i+1][31], r_wx[i+1]} - {r_wx[i][31], r_wx[i]};
            dmag = dd[32] ? 33'(-dd) : 33'(dd);
            big_all = big_all | dmag[32] | dmag[31];
            dd = {r_wy[i+1][31], r_wy[i+1]} - {r_wy[i][31], r_wy[i]};
            dmag = dd[32] ? 33'(-dd) : 33'(dd);
            big_all = big_all | dmag[32] | dmag[31];
            dd = {r_wz[i+1][31], r_wz[i+1]} - {r_wz[i][31], r_wz[i]};
            dmag = dd[32] ? 33'(-dd) : 33'(dd);
            big_all = big_all | dmag[32] | dmag[31];
        end
    end

    // knots and ratio operands
    always_comb begin
        hi_bits = |(r_k0[31:KNOT_BITS] | r_k1[31:KNOT_BITS] | r_k2[31:KNOT_BITS]);
        t1 = TT_W'({r_k0[KNOT_BITS-1:0], {T_FRAC{1'b0}}});
        t2 = t1 + TT_W'({r_k1[KNOT_BITS-1:0], {T_FRAC{1'b0}}});
        t3 = t2 + TT_W'({r_k2[KNOT_BITS-1:0], {T_FRAC{1'b0}}});
        case (r_idx)
            3'd0:    begin dv_num = r_tt;      dv_den = t1;      end
            3'd1:    begin dv_num = r_tt - t1; dv_den = t2 - t1; end
            3'd2:    begin dv_num = t2 - r_tt; dv_den = t3 - t2; end
            3'd3:    begin dv_num = r_tt;      dv_den = t2;      end
            default: begin dv_num = r_tt - t1; dv_den = t3 - t1; end
        endcase
    end

    // interpolation operands and final add
    always_comb begin
        case (r_step)
            3'd0:    begin l_p = sx64(c_p0); l_q = sx64(c_p1); l_r = r_r0; end
            3'd1:    begin l_p = sx64(c_p1); l_q = sx64(c_p2); l_r = r_r1; end
            3'd2:    begin l_p = sx64(c_p2); l_q = sx64(c_p3); l_r = r_r2; end
            3'd3:    begin l_p = r_a1;       l_q = r_a2;       l_r = r_r3; end
            3'd4:    begin l_p = r_a2;       l_q = r_a3;       l_r = r_r4; end
            default: begin l_p = r_b1;       l_q = r_b2;       l_r = r_r1; end
        endcase
        dm    = r_d[63] ? 64'(-r_d) : 64'(r_d);
        rm    = l_r[63] ? 64'(-l_r) : 64'(l_r);
        j_iss = 2'(r_cnt - 3'd1);
        j_acc = 2'(r_cnt - 3'd2);
        case (j_acc)
            2'd0:    pp_sh = 112'(r_prod);
            2'd1:    pp_sh = 112'(r_prod) << 32;
            2'd2:    pp_sh = 112'(r_prod) << 32;
            default: pp_sh = 112'(r_prod) << 64;
        endcase
        v_mag  = (|r_acc[111:86]) ? 64'(SAT_MAX) : {2'b00, r_acc[85:24]};
        v_term = (r_d[63] ^ l_r[63]) ? -$signed(v_mag) : $signed(v_mag);
        l_res  = clamp_sat({l_p[63], l_p} + {v_term[63], v_term});
    end

    // shared multiplier operands
    always_comb begin
        mul_a = m_cur;
        mul_b = m_cur;
        case (r_state)
            S_TT: begin
                mul_a = 32'(r_u);
                mul_b = r_k1;
            end
            S_LERP: begin
                case (j_iss)
                    2'd0:    begin mul_a = dm[31:0];  mul_b = rm[31:0];  end
                    2'd1:    begin mul_a = dm[31:0];  mul_b = rm[63:32]; end
                    2'd2:    begin mul_a = dm[63:32]; mul_b = rm[31:0];  end
                    default: begin mul_a = dm[63:32]; mul_b = rm[63:32]; end
                endcase
            end
            default: begin
                mul_a = m_cur;
                mul_b = m_cur;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid && i_q_item.cmd == CMD_EVAL) begin
                    n_state = (r_pts < 3'd4) ? S_OUT : S_SEG;
                end
            end
            S_SEG: begin
                if (i_alpha_mode == ALPHA_UNIFORM) begin
                    n_state = (r_seg == 2'd2) ? S_NORM : S_SEG;
                end else if (seg_eq) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_SQ;
                end
            end
            S_SQ: if (r_cnt == 3'd3) n_state = S_RT1;
            S_RT1: begin
                if (rt_done) begin
                    if (centrip) n_state = S_RT2;
                    else n_state = (r_seg == 2'd2) ? S_NORM : S_SEG;
                end
            end
            S_RT2: if (rt_done) n_state = (r_seg == 2'd2) ? S_NORM : S_SEG;
            S_NORM: if (!hi_bits) n_state = S_TT;
            S_TT: if (r_cnt == 3'd1) n_state = S_DIV;
            S_DIV: if (dv_done && r_idx == 3'd4) n_state = S_LERP;
            S_LERP: begin
                if (r_cnt == 3'd6 && r_step == 3'd5 && r_comp == 2'd2) n_state = S_OUT;
            end
            S_OUT: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // queue pop
    always_comb begin
        o_q_pop = (r_state == S_IDLE) && i_q_valid;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pts    <= '0;
            r_ovalid <= 1'b0;
            r_rt_go  <= 1'b0;
            r_dv_go  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_rt_go <= 1'b0;
            r_dv_go <= 1'b0;
            if (o_q_pop && i_q_item.cmd == CMD_PUSH && r_pts != 3'd4) begin
                r_pts <= r_pts + 3'd1;
            end
            if (r_state == S_SQ && r_cnt == 3'd3) r_rt_go <= 1'b1;
            if (r_state == S_RT1 && rt_done && centrip) r_rt_go <= 1'b1;
            if (r_state == S_TT && r_cnt == 3'd1) r_dv_go <= 1'b1;
            if (r_state == S_DIV && dv_done && r_idx != 3'd4) r_dv_go <= 1'b1;
            if (r_state == S_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_m_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (r_state)
            S_IDLE: begin
                if (o_q_pop) begin
                    if (i_q_item.cmd == CMD_PUSH) begin
                        for (int i = 0; i < 3; i++) begin
                            r_wx[i] <= r_wx[i+1];
                            r_wy[i] <= r_wy[i+1];
                            r_wz[i] <= r_wz[i+1];
                        end
                        r_wx[3] <= i_q_item.x;
                        r_wy[3] <= i_q_item.y;
                        r_wz[3] <= i_q_item.z;
                    end else begin
                        r_u     <= i_q_item.t;
                        r_big   <= big_all;
                        r_seg   <= 2'd0;
                        r_degen <= (r_pts < 3'd4);
                        r_rx    <= '0;
                        r_ry    <= '0;
                        r_rz    <= '0;
                    end
                end
            end
            S_SEG: begin
                r_sq  <= '0;
                r_cnt <= 3'd0;
                if (i_alpha_mode == ALPHA_UNIFORM) begin
                    case (r_seg)
                        2'd0:    r_k0 <= 32'd1;
                        2'd1:    r_k1 <= 32'd1;
                        default: r_k2 <= 32'd1;
                    endcase
                    r_seg <= r_seg + 2'd1;
                end else if (seg_eq) begin
                    r_degen <= 1'b1;
                end
            end
            S_SQ: begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt != 3'd0) r_sq <= r_sq + r_prod;
            end
            S_RT1, S_RT2: begin
                if (rt_done) begin
                    if (r_state == S_RT1 && centrip) begin
                        r_sq <= 64'(rt_root) << COORD_FRAC_BITS;
                    end else begin
                        case (r_seg)
                            2'd0:    r_k0 <= (rt_root == 32'd0) ? 32'd1 : rt_root;
                            2'd1:    r_k1 <= (rt_root == 32'd0) ? 32'd1 : rt_root;
                            default: r_k2 <= (rt_root == 32'd0) ? 32'd1 : rt_root;
                        endcase
                        r_seg <= r_seg + 2'd1;
                    end
                end
            end
            S_NORM: begin
                r_cnt <= 3'd0;
                if (hi_bits) begin
                    r_k0 <= r_k0 >> 1;
                    r_k1 <= r_k1 >> 1;
                    r_k2 <= r_k2 >> 1;
                end else begin
                    if (r_k0 == 32'd0) r_k0 <= 32'd1;
                    if (r_k1 == 32'd0) r_k1 <= 32'd1;
                    if (r_k2 == 32'd0) r_k2 <= 32'd1;
                    if (r_u > T_ONE) r_u <= T_ONE;
                end
            end
            S_TT: begin
                r_cnt <= r_cnt + 3'd1;
                r_idx <= 3'd0;
                if (r_cnt == 3'd1) r_tt <= t1 + r_prod[TT_W-1:0];
            end
            S_DIV: begin
                r_cnt  <= 3'd0;
                r_step <= 3'd0;
                r_comp <= 2'd0;
                if (dv_done) begin
                    r_idx <= r_idx + 3'd1;
                    case (r_idx)
                        3'd0:    r_r0 <= $signed(64'(dv_quo));
                        3'd1:    r_r1 <= $signed(64'(dv_quo));
                        3'd2:    r_r2 <= -$signed(64'(dv_quo));
                        3'd3:    r_r3 <= $signed(64'(dv_quo));
                        default: r_r4 <= $signed(64'(dv_quo));
                    endcase
                end
            end
            S_LERP: begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd0) begin
                    r_d   <= l_q - l_p;
                    r_acc <= '0;
                end
                if (r_cnt >= 3'd2 && r_cnt <= 3'd5) r_acc <= r_acc + pp_sh;
                if (r_cnt == 3'd6) begin
                    r_cnt <= 3'd0;
                    case (r_step)
                        3'd0: r_a1 <= l_res;
                        3'd1: r_a2 <= l_res;
                        3'd2: r_a3 <= l_res;
                        3'd3: r_b1 <= l_res;
                        3'd4: r_b2 <= l_res;
                        default: begin
                            case (r_comp)
                                2'd0:    r_rx <= sat32(l_res);
                                2'd1:    r_ry <= sat32(l_res);
                                default: r_rz <= sat32(l_res);
                            endcase
                        end
                    endcase
                    if (r_step == 3'd5) begin
                        r_step <= 3'd0;
                        r_comp <= r_comp + 2'd1;
                    end else begin
                        r_step <= r_step + 3'd1;
                    end
                end
            end
            S_OUT: begin
                if (out_free) begin
                    r_ox   <= r_degen ? 32'd0 : r_rx;
                    r_oy   <= r_degen ? 32'd0 : r_ry;
                    r_oz   <= r_degen ? 32'd0 : r_rz;
                    r_odeg <= r_degen;
                end
            end
            default: ;
        endcase
    end

    // shared iterative units
    cmr_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_rt_go),
        .i_val   (r_sq),
        .o_done  (rt_done),
        .o_root  (rt_root)
    );

    cmr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_dv_go),
        .i_num   (dv_num),
        .i_den   (dv_den),
        .o_done  (dv_done),
        .o_quo   (dv_quo)
    );

    assign o_m_valid = r_ovalid;
    assign o_m_x     = r_ox;
    assign o_m_y     = r_oy;
    assign o_m_z     = r_oz;
    assign o_m_degen = r_odeg;

    // checks
    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_q_valid && i_q_item.cmd == CMD_PUSH) |=> (r_pts != 3'd0))
        else $error("point count not advanced by a push");

    a_knots_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TT) |-> (r_k0[31:KNOT_BITS] == '0 && r_k1[31:KNOT_BITS] == '0 &&
                               r_k2[31:KNOT_BITS] == '0 && r_k0 != '0 && r_k1 != '0 &&
                               r_k2 != '0))
        else $error("knot intervals not normalised");

    a_div_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dv_done |-> (r_state == S_DIV))
        else $error("divider finished outside the ratio phase");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> ($past(r_state) == S_OUT))
        else $error("result shown without passing the output state");

endmodule

`default_nettype wire

// ===== src/cmr_front.sv =====
// ----------------------------------------------------------------------------
// cmr_front
// Input side: takes items, clamps the curve parameter and queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module cmr_front
    import cmr_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    output logic        o_ready,
    input  wire t_item  i_item,
    output logic        o_valid,
    output t_item       o_item,
    input  wire logic   i_pop
);

    t_item            r_mem [QDEPTH];
    logic [QP_W-1:0]  r_wptr;
    logic [QP_W-1:0]  r_rptr;
    logic [QC_W-1:0]  r_cnt;
    t_item            cls;
    logic             wr;

    // parameter above one reads as one
    always_comb begin
        cls = i_item;
        if (i_item.t > T_ONE) cls.t = T_ONE;
    end

    assign o_ready = (r_cnt != QC_W'(QDEPTH));
    assign wr      = i_valid && o_ready;
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rptr];

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (wr) r_wptr <= (r_wptr == QP_W'(QDEPTH - 1)) ? '0 : r_wptr + QP_W'(1);
            if (i_pop) r_rptr <= (r_rptr == QP_W'(QDEPTH - 1)) ? '0 : r_rptr + QP_W'(1);
            if (wr && !i_pop) r_cnt <= r_cnt + QC_W'(1);
            else if (!wr && i_pop) r_cnt <= r_cnt - QC_W'(1);
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wptr] <= cls;
    end

endmodule

`default_nettype wire

// ===== src/catmull_rom_spline_eval_unit.sv =====
// ----------------------------------------------------------------------------
// catmull_rom_spline_eval_unit
// Catmull-Rom spline point evaluator over a four-point window, fixed point.
// ----------------------------------------------------------------------------
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata x,y,z,t   tuser cmd
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata x,y,z     tuser degenerate
// cfg       in   i_cfg_valid/o_cfg_ready      alpha_mode
//
// a push shifts the window in the back end; an evaluation runs the bit-serial
// divider for five ratios, the bit-serial square root for three or six roots
// (chordal or centripetal mode) and 18 multiply passes, plus knot normalisation
// shifts. a window that is not full goes straight to the output state; outside
// uniform mode, coincident points end the evaluation at the segment where they
// are found.
// reset is synchronous and active low; window contents need no reset.
// a two-entry queue keeps accepting, until full, while the back end works or a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module catmull_rom_spline_eval_unit
    import cmr_pkg::*;
#(
    parameter int COORD_FRAC_BITS = COORD_FRAC_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [119:0] s_axis_tdata,   // coord_x, coord_y, coord_z, sample_t, pad
    input  wire logic         s_axis_tuser,   // cmd
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [95:0]       m_axis_tdata,   // out_x, out_y, out_z
    output logic              m_axis_tuser,   // degenerate
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_data
);

    logic [1:0] r_alpha;
    t_item      in_item;
    t_item      q_item;
    logic       q_valid;
    logic       q_pop;
    logic [31:0] m_x, m_y, m_z;

    // knot exponent register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ALPHA_CENTRIP;
        end else if (i_cfg_valid) begin
            r_alpha <= i_cfg_data;
        end
    end

    // unpack the incoming transfer
    always_comb begin
        in_item.cmd = s_axis_tuser;
        in_item.x   = s_axis_tdata[31:0];
        in_item.y   = s_axis_tdata[63:32];
        in_item.z   = s_axis_tdata[95:64];
        in_item.t   = s_axis_tdata[112:96];
    end

    cmr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    cmr_back #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_alpha_mode (r_alpha),
        .i_q_valid    (q_valid),
        .i_q_item     (q_item),
        .o_q_pop      (q_pop),
        .o_m_valid    (m_axis_tvalid),
        .i_m_ready    (m_axis_tready),
        .o_m_x        (m_x),
        .o_m_y        (m_y),
        .o_m_z        (m_z),
        .o_m_degen    (m_axis_tuser)
    );

    assign m_axis_tdata = {m_z, m_y, m_x};

endmodule

`default_nettype wire

// ===== test/tb_catmull_rom_spline_eval_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_catmull_rom_spline_eval_unit
// Streams push and evaluate commands into the spline evaluator. A bit-exact
// fixed point predictor keeps its own point window and knot mode, and every
// returned point is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_catmull_rom_spline_eval_unit
    import cmr_pkg::*;
;

    localparam int FRAC = 16;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic               degen;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
    } t_point;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [119:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [95:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_data;

    catmull_rom_spline_eval_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // predictor state
    logic signed [31:0] win_x[4];
    logic signed [31:0] win_y[4];
    logic signed [31:0] win_z[4];
    int unsigned        n_loaded;
    logic [1:0]         knot_mode;

    t_item  pending_items[$];
    t_point expected_points[$];
    int     n_errors;
    int     n_points;
    int     n_degen;
    int     idle_cycles;
    int     drv_wait;
    int     rx_wait;
    int     hold_off;
    bit     cfg_busy;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] mag(input logic signed [63:0] v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] root_floor(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic signed [63:0] frac_of(input logic signed [63:0] num,
                                                   input logic signed [63:0] den);
        logic [127:0] q;
        if (den <= 0) return 0;
        q = ({64'd0, mag(num)} << R_FRAC) / 128'(den);
        return num < 0 ? -$signed(q[63:0]) : $signed(q[63:0]);
    endfunction

    function automatic logic signed [63:0] blend(input logic signed [63:0] a,
                                                 input logic signed [63:0] b,
                                                 input logic signed [63:0] r);
        logic signed [64:0]  diff;
        logic [64:0]         dm;
        logic [127:0]        prod;
        logic [127:0]        sh;
        logic [63:0]         v;
        logic signed [65:0]  sum;
        diff = 65'(b) - 65'(a);
        dm = diff < 0 ? 65'(-diff) : 65'(diff);
        // the difference is taken modulo 2^64 as in 64-bit integer code
        dm = {1'b0, dm[63:0]};
        if (diff[63] != diff[64]) dm = {1'b0, mag($signed(diff[63:0]))};
        prod = 128'(dm[63:0]) * 128'(mag(r));
        sh = prod >> R_FRAC;
        v = (sh[127:64] != 0) ? 64'(SAT_MAX) : sh[63:0];
        if (v > 64'(SAT_MAX)) v = 64'(SAT_MAX);
        sum = 66'(a) + (($signed(diff[63:0]) < 0) != (r < 0) ? -66'(v) : 66'(v));
        if (sum > 66'(SAT_MAX)) return SAT_MAX;
        if (sum < -66'(SAT_MAX)) return -SAT_MAX;
        return sum[63:0];
    endfunction

    // spline point for the current window
    function automatic t_point eval_point(input logic [16:0] t_in);
        t_point             res;
        logic signed [63:0] p[4][3];
        logic signed [63:0] d[3][3];
        logic [63:0]        k[3];
        logic [63:0]        sq;
        logic [63:0]        m;
        logic [63:0]        mx;
        logic [63:0]        u;
        logic signed [63:0] t1, t2, t3, tt;
        logic signed [63:0] r[6];
        logic signed [63:0] a1, a2, a3, b1, b2, v;
        bit                 big;
        int                 sh;
        res = '0;
        big = 0;
        res.degen = n_loaded < 4;
        for (int i = 0; i < 4; i++) begin
            p[i][0] = win_x[i];
            p[i][1] = win_y[i];
            p[i][2] = win_z[i];
        end
        for (int i = 0; i < 3; i++)
            for (int c = 0; c < 3; c++) begin
                d[i][c] = p[i+1][c] - p[i][c];
                if (mag(d[i][c]) >= 64'd1 << 31) big = 1;
            end
        for (int i = 0; i < 3; i++) begin
            sq = 0;
            if (knot_mode == ALPHA_UNIFORM) begin
                k[i] = 1;
            end else if (d[i][0] == 0 && d[i][1] == 0 && d[i][2] == 0) begin
                res.degen = 1;
                k[i] = 1;
            end else begin
                for (int c = 0; c < 3; c++) begin
                    m = mag(d[i][c]) >> (big ? 1 : 0);
                    sq = sq + m * m;
                end
                k[i] = root_floor(sq);
                if (knot_mode == ALPHA_CENTRIP) k[i] = root_floor(k[i] << FRAC);
                if (k[i] == 0) k[i] = 1;
            end
        end
        if (res.degen) return res;
        mx = k[0];
        if (k[1] > mx) mx = k[1];
        if (k[2] > mx) mx = k[2];
        sh = 0;
        while ((mx >> KNOT_BITS) != 0) begin
            mx = mx >> 1;
            sh++;
        end
        for (int i = 0; i < 3; i++) begin
            k[i] = k[i] >> sh;
            if (k[i] == 0) k[i] = 1;
        end
        u = (t_in > T_ONE) ? 64'(T_ONE) : 64'(t_in);
        t1 = k[0] << T_FRAC;
        t2 = t1 + (k[1] << T_FRAC);
        t3 = t2 + (k[2] << T_FRAC);
        tt = t1 + u * k[1];
        r[0] = frac_of(tt, t1);
        r[1] = frac_of(tt - t1, t2 - t1);
        r[2] = frac_of(tt - t2, t3 - t2);
        r[3] = frac_of(tt, t2);
        r[4] = frac_of(tt - t1, t3 - t1);
        r[5] = r[1];
        for (int c = 0; c < 3; c++) begin
            a1 = blend(p[0][c], p[1][c], r[0]);
            a2 = blend(p[1][c], p[2][c], r[1]);
            a3 = blend(p[2][c], p[3][c], r[2]);
            b1 = blend(a1, a2, r[3]);
            b2 = blend(a2, a3, r[4]);
            v = sat32(blend(b1, b2, r[5]));
            if (c == 0) res.px = v[31:0];
            else if (c == 1) res.py = v[31:0];
            else res.pz = v[31:0];
        end
        return res;
    endfunction

    // predictor update for one accepted item
    task automatic apply_item(input t_item it);
        if (it.cmd == CMD_PUSH) begin
            for (int i = 0; i < 3; i++) begin
                win_x[i] = win_x[i+1];
                win_y[i] = win_y[i+1];
                win_z[i] = win_z[i+1];
            end
            win_x[3] = it.x;
            win_y[3] = it.y;
            win_z[3] = it.z;
            if (n_loaded < 4) n_loaded++;
        end else begin
            expected_points.insert(expected_points.size(), eval_point(it.t));
        end
    endtask

    // append one item to the stimulus queue
    task automatic add_item(input t_item it);
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        n_errors++;
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    endtask

    function automatic t_item make_push(input logic [31:0] x, input logic [31:0] y,
                                        input logic [31:0] z);
        t_item it;
        it.cmd = CMD_PUSH;
        it.x = x;
        it.y = y;
        it.z = z;
        it.t = 17'($urandom);
        return it;
    endfunction

    function automatic t_item make_eval(input logic [16:0] t);
        t_item it;
        it.cmd = CMD_EVAL;
        it.x = $urandom;
        it.y = $urandom;
        it.z = $urandom;
        it.t = t;
        return it;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2000)) - 1000);
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 400000)) - 200000) <<< 4;
        endcase
    endfunction

    function automatic logic [16:0] rand_t();
        case ($urandom_range(0, 7))
            0: return 17'($urandom);
            1: return $urandom_range(0, 1) ? 17'd0 : T_ONE;
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    // driver: feeds the input stream from the pending queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            drv_wait <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                apply_item(pending_items.pop_front());
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (drv_wait > 0) begin
                    drv_wait <= drv_wait - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_items.size() > 0 && !cfg_busy) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {7'd0, pending_items[0].t, pending_items[0].z,
                                     pending_items[0].y, pending_items[0].x};
                    s_axis_tuser <= pending_items[0].cmd;
                    drv_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks returned points against predictions
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_points.size() == 0) begin
                    report("unexpected point", m_axis_tdata[31:0], 32'd0);
                end else begin
                    t_point e;
                    e = expected_points.pop_front();
                    n_points++;
                    if (e.degen) n_degen++;
                    if (m_axis_tdata[31:0] !== e.px) report("out_x", m_axis_tdata[31:0], e.px);
                    if (m_axis_tdata[63:32] !== e.py) report("out_y", m_axis_tdata[63:32], e.py);
                    if (m_axis_tdata[95:64] !== e.pz) report("out_z", m_axis_tdata[95:64], e.pz);
                    if (m_axis_tuser !== e.degen)
                        report("degenerate", 32'(m_axis_tuser), 32'(e.degen));
                end
            end
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_axis_tready <= 1'b0;
            end else if (m_axis_tready && m_axis_tvalid || !m_axis_tready && rx_wait == 0) begin
                rx_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
                m_axis_tready <= ($urandom_range(0, 3) == 0) ? 1'b0 : 1'b1;
            end else if (!m_axis_tready) begin
                rx_wait <= rx_wait - 1;
            end
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic settle();
        while (pending_items.size() > 0 || s_axis_tvalid || expected_points.size() > 0)
            @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic [1:0] mode);
        settle();
        cfg_busy = 1;
        i_cfg_valid <= 1'b1;
        i_cfg_data <= mode;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        knot_mode = mode;
        cfg_busy = 0;
    endtask

    task automatic queue_random(input int count);
        int made;
        made = 0;
        while (made < count) begin
            if ($urandom_range(0, 9) == 0) begin
                // stray item or bare evaluate
                add_item($urandom_range(0, 1) ?
                    make_eval(rand_t()) : make_push(rand_coord(), rand_coord(), rand_coord()));
                made++;
            end else begin
                int np;
                np = $urandom_range(1, 4);
                for (int i = 0; i < np; i++)
                    add_item(make_push(rand_coord(), rand_coord(), rand_coord()));
                add_item(make_eval(rand_t()));
                add_item(make_eval(rand_t()));
                made += np + 2;
            end
        end
    endtask

    initial begin
        logic [1:0] modes[6];
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        n_errors = 0;
        n_points = 0;
        n_degen = 0;
        idle_cycles = 0;
        hold_off = 0;
        cfg_busy = 0;
        for (int i = 0; i < 4; i++) begin
            win_x[i] = 0;
            win_y[i] = 0;
            win_z[i] = 0;
        end
        n_loaded = 0;
        knot_mode = ALPHA_CENTRIP;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty window, partial fill, extremes, coincident points
        add_item(make_eval(17'd0));
        add_item(make_push(32'h8000_0000, 32'h7FFF_FFFF, 32'h0));
        add_item(make_eval(T_ONE));
        add_item(make_push(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF));
        add_item(make_push(32'h0001_0000, 32'h0002_0000, 32'h0003_0000));
        add_item(make_push(32'h0001_0000, 32'h0002_0000, 32'h0003_0000));
        add_item(make_eval(17'h08000));
        add_item(make_push(32'h0004_0000, 32'hFFFE_0000, 32'h0000_0001));
        add_item(make_eval(17'h0));
        add_item(make_eval(17'h10000));
        add_item(make_eval(17'h1FFFF));
        add_item(make_push(32'h0004_0001, 32'hFFFE_0000, 32'h0000_0001));
        add_item(make_eval(17'h04000));
        add_item(make_push(32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        add_item(make_eval(17'h0C000));
        add_item(make_eval(17'h10001));

        // long receiver hold-off while the sender keeps offering
        hold_off = 3000;
        modes = '{ALPHA_UNIFORM, 2'd2, 2'd3, ALPHA_CENTRIP, 2'd2, ALPHA_UNIFORM};
        queue_random(60);
        for (int ph = 0; ph < 6; ph++) begin
            write_mode(modes[ph]);
            // a window of four coincident points is evaluated in uniform mode too
            if (ph == 0) begin
                for (int i = 0; i < 4; i++)
                    add_item(make_push(32'h0001_0000, 32'h0001_0000, 32'h0));
                add_item(make_eval(17'h08000));
            end
            queue_random(175);
        end
        settle();
        $display("covered %0d points (%0d degenerate) over all knot modes", n_points, n_degen);
        if (n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
